// File: hw/rtl/dual_lane_int8_mac_unit_macros.svh
// Assertion helpers for the multiply-accumulate unit.
// They expect signals named clk and arst_n in the enclosing module.
`ifndef DUAL_LANE_INT8_MAC_UNIT_MACROS_SVH
`define DUAL_LANE_INT8_MAC_UNIT_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define DLM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that must be followed by another in the next cycle.
`define DLM_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: hw/rtl/dlm_pkg.sv
package dlm_pkg;

	// Fixed lane geometry: eight bytes per beat, one bank per byte.
	localparam int MAC_BYTES = 8;
	localparam int BANK_BITS = 3;

	// Host actions.
	localparam logic [2:0] ACT_EXEC     = 3'd0;
	localparam logic [2:0] ACT_HOST_WR  = 3'd1;
	localparam logic [2:0] ACT_COEF0_WR = 3'd2;
	localparam logic [2:0] ACT_COEF1_WR = 3'd3;
	localparam logic [2:0] ACT_HOST_RD  = 3'd4;

	// Instruction opcodes.
	localparam logic [5:0] OP_VB_SET = 6'd8;
	localparam logic [5:0] OP_VB_ADD = 6'd9;
	localparam logic [5:0] OP_LB_SET = 6'd10;
	localparam logic [5:0] OP_LB_ADD = 6'd11;
	localparam logic [5:0] OP_SB_SET = 6'd12;
	localparam logic [5:0] OP_SB_ADD = 6'd13;
	localparam logic [5:0] OP_CB_SET = 6'd14;
	localparam logic [5:0] OP_CB_ADD = 6'd15;
	localparam logic [5:0] OP_STORE  = 6'd16;
	localparam logic [5:0] OP_STORE0 = 6'd17;
	localparam logic [5:0] OP_STORE1 = 6'd18;
	localparam logic [5:0] OP_RELU   = 6'd20;
	localparam logic [5:0] OP_RELU0  = 6'd21;
	localparam logic [5:0] OP_RELU1  = 6'd22;
	localparam logic [5:0] OP_SAVE   = 6'd24;
	localparam logic [5:0] OP_SAVE0  = 6'd25;
	localparam logic [5:0] OP_SAVE1  = 6'd26;
	localparam logic [5:0] OP_LOAD   = 6'd28;
	localparam logic [5:0] OP_LOAD0  = 6'd29;
	localparam logic [5:0] OP_LOAD1  = 6'd30;
	localparam logic [5:0] OP_LADD   = 6'd32;
	localparam logic [5:0] OP_LADD0  = 6'd33;
	localparam logic [5:0] OP_LADD1  = 6'd34;
	localparam logic [5:0] OP_MACC   = 6'd40;
	localparam logic [5:0] OP_MMAX   = 6'd41;
	localparam logic [5:0] OP_MACCZ  = 6'd42;
	localparam logic [5:0] OP_MMAXZ  = 6'd43;
	localparam logic [5:0] OP_MMAXN  = 6'd45;

	// Lane selection held in the two low opcode bits.
	localparam logic [1:0] SEL_LANE0 = 2'd1;
	localparam logic [1:0] SEL_LANE1 = 2'd2;

	// Status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_UNKNOWN = 2'd1;
	localparam logic [1:0] ST_ODD     = 2'd2;
	localparam logic [1:0] ST_SHIFT   = 2'd3;

	// Numeric constants.
	localparam logic [8:0]  SHIFT_LIMIT = 9'd32;
	localparam logic [31:0] ACC_MIN     = 32'h8000_0000;
	localparam logic signed [31:0] CLAMP_HI = 32'sd127;
	localparam logic signed [31:0] CLAMP_LO = -32'sd128;

	typedef struct packed {
		logic [2:0]  action;
		logic [5:0]  opcode;
		logic [16:0] mem_offset;
		logic [8:0]  coeff_offset;
		logic [63:0] write_data;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] acc_lane0;
		logic signed [31:0] acc_lane1;
		logic [63:0]        read_data;
		logic [1:0]         status;
	} rsp_t;

	typedef enum logic [2:0] {
		K_NONE,
		K_STORE,
		K_SAVE,
		K_LOAD,
		K_MAC,
		K_HOST_RD
	} kind_t;

	// Decoded instruction as it travels down the pipeline.
	typedef struct packed {
		kind_t       kind;
		logic [1:0]  status;
		logic        relu;
		logic        lane0;
		logic        lane1;
		logic        add;
		logic        use_max;
		logic        preset_zero;
		logic        preset_min;
		logic [4:0]  shift;
		logic [16:0] addr;
	} ctl_t;

	// Eight-byte window write into main memory.
	typedef struct packed {
		logic [7:0]  be;
		logic [16:0] addr;
		logic [63:0] data;
	} mem_wr_t;

	// Reduced lane products.
	typedef struct packed {
		logic signed [18:0] sum0;
		logic signed [18:0] sum1;
		logic signed [15:0] max0;
		logic               max0_v;
	} mac_red_t;

endpackage

// File: hw/rtl/dlm_stream_if.sv
interface dlm_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/dual_lane_int8_mac_unit.sv
// Dual-lane int8 multiply-accumulate unit.
// Commands arrive on the cmd channel, one per beat; each produces exactly one
// beat on the rsp channel with both accumulators, host read data and status.
// A command passes through stages s1 and s2 and then the output register before
// its response is valid. One command is taken per cycle while the pipeline has
// room; the exception is a command that touches main memory arriving while a
// store or save is still in the pipeline, which waits until that write has
// reached the byte banks; a stalled receiver holds that write back as well.
// Main memory is eight byte banks, each with one write and one registered read
// port, so an eight-byte window at any byte address is read or written at once.
// Both coefficient banks are read in the acceptance cycle alongside it.
// Reset clears the base pointers, accumulators and pipeline; memory contents are
// undefined until written and need no clearing pass.
// When the receiver stalls, the output register holds its beat and the stages
// behind it keep filling, so cmd stays ready until every stage is occupied.
`include "dual_lane_int8_mac_unit_macros.svh"

module dual_lane_int8_mac_unit #(
	parameter int MAIN_BYTES  = 131072,
	parameter int COEFF_WORDS = 512
) (
	input logic         clk,
	input logic         arst_n,
	dlm_stream_if.sink   cmd,
	dlm_stream_if.source rsp
);
	logic [16:0] vb_q, lb_q, sb_q;
	logic [8:0]  cb_q;
	logic [16:0] vb_d, lb_d, sb_d;
	logic [8:0]  cb_d;
	logic [31:0] acc0_q, acc1_q;
	logic [31:0] acc0_d, acc1_d;

	dlm_pkg::ctl_t     ctl_s0, ctl_s1, ctl_s2;
	dlm_pkg::mac_red_t red, red_s2;
	logic              s1_v_q, s2_v_q, out_v_q;
	dlm_pkg::rsp_t     rsp_q, rsp_d;
	logic [63:0]       data_s2;
	logic [63:0]       mem_rd;
	logic [63:0]       coef0, coef1;
	logic [8:0]        coef_addr;

	logic host_we, coef_we0, coef_we1, touch_main;
	logic store_pending, acc_in;
	logic out_en, s2_en, s1_en;
	logic store_we;
	dlm_pkg::mem_wr_t wr_req, store_req;

	// Decode the incoming beat against the current base pointers.
	always_comb begin
		ctl_s0        = '0;
		ctl_s0.kind   = dlm_pkg::K_NONE;
		ctl_s0.status = dlm_pkg::ST_OK;
		ctl_s0.shift  = cmd.data.coeff_offset[4:0];
		ctl_s0.addr   = cmd.data.mem_offset;
		vb_d     = vb_q;
		lb_d     = lb_q;
		sb_d     = sb_q;
		cb_d     = cb_q;
		host_we  = 1'b0;
		coef_we0 = 1'b0;
		coef_we1 = 1'b0;
		unique case (cmd.data.action)
			dlm_pkg::ACT_EXEC: begin
				unique case (cmd.data.opcode)
					dlm_pkg::OP_VB_SET: vb_d = cmd.data.mem_offset;
					dlm_pkg::OP_VB_ADD: vb_d = vb_q + cmd.data.mem_offset;
					dlm_pkg::OP_LB_SET: lb_d = cmd.data.mem_offset;
					dlm_pkg::OP_LB_ADD: lb_d = lb_q + cmd.data.mem_offset;
					dlm_pkg::OP_SB_SET: sb_d = cmd.data.mem_offset;
					dlm_pkg::OP_SB_ADD: sb_d = sb_q + cmd.data.mem_offset;
					dlm_pkg::OP_CB_SET: cb_d = cmd.data.coeff_offset;
					dlm_pkg::OP_CB_ADD: cb_d = cb_q + cmd.data.coeff_offset;
					dlm_pkg::OP_STORE, dlm_pkg::OP_STORE0, dlm_pkg::OP_STORE1,
					dlm_pkg::OP_RELU, dlm_pkg::OP_RELU0, dlm_pkg::OP_RELU1: begin
						ctl_s0.addr  = sb_q + cmd.data.mem_offset;
						ctl_s0.relu  = cmd.data.opcode[2];
						ctl_s0.lane0 = cmd.data.opcode[1:0] != dlm_pkg::SEL_LANE1;
						ctl_s0.lane1 = cmd.data.opcode[1:0] != dlm_pkg::SEL_LANE0;
						if (cmd.data.coeff_offset >= dlm_pkg::SHIFT_LIMIT) begin
							ctl_s0.status = dlm_pkg::ST_SHIFT;
						end else begin
							ctl_s0.kind = dlm_pkg::K_STORE;
						end
					end
					dlm_pkg::OP_SAVE, dlm_pkg::OP_SAVE0, dlm_pkg::OP_SAVE1: begin
						ctl_s0.addr  = sb_q + cmd.data.mem_offset;
						ctl_s0.lane0 = cmd.data.opcode[1:0] != dlm_pkg::SEL_LANE1;
						ctl_s0.lane1 = cmd.data.opcode[1:0] != dlm_pkg::SEL_LANE0;
						if (ctl_s0.addr[0]) begin
							ctl_s0.status = dlm_pkg::ST_ODD;
						end else begin
							ctl_s0.kind = dlm_pkg::K_SAVE;
						end
					end
					dlm_pkg::OP_LOAD, dlm_pkg::OP_LOAD0, dlm_pkg::OP_LOAD1,
					dlm_pkg::OP_LADD, dlm_pkg::OP_LADD0, dlm_pkg::OP_LADD1: begin
						ctl_s0.addr  = lb_q + cmd.data.mem_offset;
						ctl_s0.add   = cmd.data.opcode[5];
						ctl_s0.lane0 = cmd.data.opcode[1:0] != dlm_pkg::SEL_LANE1;
						ctl_s0.lane1 = cmd.data.opcode[1:0] != dlm_pkg::SEL_LANE0;
						if (ctl_s0.addr[0]) begin
							ctl_s0.status = dlm_pkg::ST_ODD;
						end else begin
							ctl_s0.kind = dlm_pkg::K_LOAD;
						end
					end
					dlm_pkg::OP_MACC, dlm_pkg::OP_MMAX, dlm_pkg::OP_MACCZ,
					dlm_pkg::OP_MMAXZ, dlm_pkg::OP_MMAXN: begin
						ctl_s0.addr        = vb_q + cmd.data.mem_offset;
						ctl_s0.use_max     = cmd.data.opcode[0];
						ctl_s0.preset_zero = cmd.data.opcode[1];
						ctl_s0.preset_min  = cmd.data.opcode[2];
						if (ctl_s0.addr[0]) begin
							ctl_s0.status = dlm_pkg::ST_ODD;
						end else begin
							ctl_s0.kind = dlm_pkg::K_MAC;
						end
					end
					default: ctl_s0.status = dlm_pkg::ST_UNKNOWN;
				endcase
			end
			dlm_pkg::ACT_HOST_WR:  host_we  = 1'b1;
			dlm_pkg::ACT_COEF0_WR: coef_we0 = 1'b1;
			dlm_pkg::ACT_COEF1_WR: coef_we1 = 1'b1;
			dlm_pkg::ACT_HOST_RD:  ctl_s0.kind = dlm_pkg::K_HOST_RD;
			default:               ctl_s0.status = dlm_pkg::ST_UNKNOWN;
		endcase
		touch_main = host_we || (ctl_s0.kind != dlm_pkg::K_NONE);
	end

	assign coef_addr = cb_q + cmd.data.coeff_offset;

	// Stage enables: each stage moves when the one after it has room.
	assign out_en = !out_v_q || rsp.ready;
	assign s2_en  = !s2_v_q || out_en;
	assign s1_en  = !s1_v_q || s2_en;

	// A store or save still in flight blocks main-memory traffic until it lands.
	assign store_pending =
		(s1_v_q && ((ctl_s1.kind == dlm_pkg::K_STORE) || (ctl_s1.kind == dlm_pkg::K_SAVE))) ||
		(s2_v_q && ((ctl_s2.kind == dlm_pkg::K_STORE) || (ctl_s2.kind == dlm_pkg::K_SAVE)));
	assign cmd.ready = s1_en && !(touch_main && store_pending);
	assign acc_in    = cmd.valid && cmd.ready;

	// Write port: a host write at acceptance, or a store or save leaving the last stage.
	assign store_we = s2_v_q && out_en && (store_req.be != 8'd0);
	always_comb begin
		if (acc_in && host_we) begin
			wr_req.be   = 8'hff;
			wr_req.addr = cmd.data.mem_offset;
			wr_req.data = cmd.data.write_data;
		end else if (store_we) begin
			wr_req = store_req;
		end else begin
			wr_req = '0;
		end
	end

	dlm_main_mem #(
		.MAIN_BYTES (MAIN_BYTES)
	) u_main (
		.clk     (clk),
		.rd_en   (acc_in),
		.rd_addr (ctl_s0.addr),
		.rd_data (mem_rd),
		.wr      (wr_req)
	);

	dlm_coeff_mem #(
		.COEFF_WORDS (COEFF_WORDS)
	) u_coeff (
		.clk     (clk),
		.wr_en0  (acc_in && coef_we0),
		.wr_en1  (acc_in && coef_we1),
		.wr_addr (cmd.data.coeff_offset),
		.wr_data (cmd.data.write_data),
		.rd_en   (acc_in),
		.rd_addr (coef_addr),
		.rd_c0   (coef0),
		.rd_c1   (coef1)
	);

	dlm_mac_reduce u_reduce (
		.vec (mem_rd),
		.c0  (coef0),
		.c1  (coef1),
		.red (red)
	);

	// Base pointers change as the beat is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vb_q <= '0;
			lb_q <= '0;
			sb_q <= '0;
			cb_q <= '0;
		end else if (acc_in) begin
			vb_q <= vb_d;
			lb_q <= lb_d;
			sb_q <= sb_d;
			cb_q <= cb_d;
		end
	end

	// Pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			s2_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s1_en) begin
				s1_v_q <= acc_in;
			end
			if (s2_en) begin
				s2_v_q <= s1_v_q;
			end
			if (out_en) begin
				out_v_q <= s2_v_q;
			end
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (s1_en) begin
			ctl_s1 <= ctl_s0;
		end
		if (s2_en) begin
			ctl_s2  <= ctl_s1;
			red_s2  <= red;
			data_s2 <= mem_rd;
		end
		if (out_en) begin
			rsp_q <= rsp_d;
		end
	end

	// Shift, then clamp to a signed byte or to the ReLU range.
	function automatic logic [7:0] clamp_byte(logic [31:0] acc, logic [4:0] sh, logic relu);
		logic signed [31:0] v;
		v = $signed(acc) >>> sh;
		if (v > dlm_pkg::CLAMP_HI) begin
			return dlm_pkg::CLAMP_HI[7:0];
		end else if (relu && (v < 32'sd0)) begin
			return 8'd0;
		end else if (!relu && (v < dlm_pkg::CLAMP_LO)) begin
			return dlm_pkg::CLAMP_LO[7:0];
		end
		return v[7:0];
	endfunction

	// Last stage: accumulator update, store data and the response beat.
	always_comb begin
		logic [31:0] base0, base1;
		base0  = ctl_s2.preset_min ? dlm_pkg::ACC_MIN :
		         (ctl_s2.preset_zero ? 32'd0 : acc0_q);
		base1  = (ctl_s2.preset_min || ctl_s2.preset_zero) ? 32'd0 : acc1_q;
		acc0_d = acc0_q;
		acc1_d = acc1_q;
		store_req      = '0;
		store_req.addr = ctl_s2.addr;
		unique case (ctl_s2.kind)
			dlm_pkg::K_LOAD: begin
				if (ctl_s2.lane0) begin
					acc0_d = ctl_s2.add ? acc0_q + data_s2[31:0] : data_s2[31:0];
				end
				if (ctl_s2.lane1) begin
					acc1_d = ctl_s2.add ? acc1_q + data_s2[63:32] : data_s2[63:32];
				end
			end
			dlm_pkg::K_MAC: begin
				if (ctl_s2.use_max) begin
					acc0_d = (red_s2.max0_v && ($signed({{16{red_s2.max0[15]}}, red_s2.max0})
					          > $signed(base0))) ?
					         {{16{red_s2.max0[15]}}, red_s2.max0} : base0;
				end else begin
					acc0_d = base0 + {{13{red_s2.sum0[18]}}, red_s2.sum0};
				end
				acc1_d = base1 + {{13{red_s2.sum1[18]}}, red_s2.sum1};
			end
			dlm_pkg::K_STORE: begin
				store_req.be[0]     = ctl_s2.lane0;
				store_req.be[1]     = ctl_s2.lane1;
				store_req.data[7:0] = clamp_byte(acc0_q, ctl_s2.shift, ctl_s2.relu);
				store_req.data[15:8] = clamp_byte(acc1_q, ctl_s2.shift, ctl_s2.relu);
			end
			dlm_pkg::K_SAVE: begin
				store_req.be   = {{4{ctl_s2.lane1}}, {4{ctl_s2.lane0}}};
				store_req.data = {acc1_q, acc0_q};
			end
			default: begin
			end
		endcase
		rsp_d.acc_lane0 = acc0_d;
		rsp_d.acc_lane1 = acc1_d;
		rsp_d.read_data = (ctl_s2.kind == dlm_pkg::K_HOST_RD) ? data_s2 : 64'd0;
		rsp_d.status    = ctl_s2.status;
	end

	// Accumulators commit as the beat enters the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc0_q <= '0;
			acc1_q <= '0;
		end else if (s2_v_q && out_en) begin
			acc0_q <= acc0_d;
			acc1_q <= acc1_d;
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.data  = rsp_q;

	// Checks on the memory interlock and the last stage.
	`DLM_ASSERT(a_no_mem_hazard, !(acc_in && touch_main && store_pending), "beat over store")
	`DLM_ASSERT(a_single_writer, !(acc_in && host_we && store_we), "two memory writers")
	`DLM_ASSERT(a_write_ok, !store_we || (ctl_s2.status == dlm_pkg::ST_OK), "failed op wrote")
	`DLM_ASSERT_NEXT(a_result_follows, s2_v_q && out_en, out_v_q, "finished beat lost")
endmodule

// File: hw/rtl/dlm_main_mem.sv
module dlm_main_mem #(
	parameter int MAIN_BYTES = 131072
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [16:0]      rd_addr,
	output logic [63:0]      rd_data,
	input  dlm_pkg::mem_wr_t wr
);
	localparam int BANKS = dlm_pkg::MAC_BYTES;
	localparam int AW    = $clog2(MAIN_BYTES);
	localparam int ROWS  = MAIN_BYTES / BANKS;
	localparam int RW    = AW - dlm_pkg::BANK_BITS;

	logic [7:0] bank_dout [BANKS];
	logic [2:0] lo_q;

	// One byte bank per byte of the window; a window starting at any byte touches each bank once.
	for (genvar b = 0; b < BANKS; b++) begin : g_bank
		logic [7:0]    bank_q [ROWS];
		logic [7:0]    dout_q;
		logic [RW-1:0] rrow;
		logic [RW-1:0] wrow;
		logic [2:0]    wk;

		always_comb begin
			rrow = rd_addr[AW-1:3] + RW'(3'(b) < rd_addr[2:0]);
			wrow = wr.addr[AW-1:3] + RW'(3'(b) < wr.addr[2:0]);
			wk   = 3'(b) - wr.addr[2:0];
		end

		always_ff @(posedge clk) begin
			if (wr.be[wk]) begin
				bank_q[wrow] <= wr.data[8*wk +: 8];
			end
			if (rd_en) begin
				dout_q <= bank_q[rrow];
			end
		end

		assign bank_dout[b] = dout_q;
	end

	// Remember the window start so the bank outputs can be put back in byte order.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			lo_q <= rd_addr[2:0];
		end
	end

	always_comb begin
		for (int k = 0; k < BANKS; k++) begin
			rd_data[8*k +: 8] = bank_dout[3'(lo_q + 3'(k))];
		end
	end
endmodule

// File: hw/rtl/dlm_coeff_mem.sv
module dlm_coeff_mem #(
	parameter int COEFF_WORDS = 512
) (
	input  logic        clk,
	input  logic        wr_en0,
	input  logic        wr_en1,
	input  logic [8:0]  wr_addr,
	input  logic [63:0] wr_data,
	input  logic        rd_en,
	input  logic [8:0]  rd_addr,
	output logic [63:0] rd_c0,
	output logic [63:0] rd_c1
);
	localparam int CW = $clog2(COEFF_WORDS);

	logic [63:0] bank0_q [COEFF_WORDS];
	logic [63:0] bank1_q [COEFF_WORDS];

	// Both banks share an index, so a multiply beat reads them side by side.
	always_ff @(posedge clk) begin
		if (wr_en0) begin
			bank0_q[wr_addr[CW-1:0]] <= wr_data;
		end
		if (wr_en1) begin
			bank1_q[wr_addr[CW-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rd_c0 <= bank0_q[rd_addr[CW-1:0]];
			rd_c1 <= bank1_q[rd_addr[CW-1:0]];
		end
	end
endmodule

// File: hw/rtl/dlm_mac_reduce.sv
module dlm_mac_reduce (
	input  logic [63:0]       vec,
	input  logic [63:0]       c0,
	input  logic [63:0]       c1,
	output dlm_pkg::mac_red_t red
);
	logic signed [15:0] p0 [dlm_pkg::MAC_BYTES];
	logic signed [15:0] p1 [dlm_pkg::MAC_BYTES];

	// Eight signed byte products per lane.
	always_comb begin
		for (int i = 0; i < dlm_pkg::MAC_BYTES; i++) begin
			p0[i] = $signed(vec[8*i +: 8]) * $signed(c0[8*i +: 8]);
			p1[i] = $signed(vec[8*i +: 8]) * $signed(c1[8*i +: 8]);
		end
	end

	// Lane sums, and the largest lane-0 product whose coefficient is nonzero.
	always_comb begin
		red = '0;
		for (int i = 0; i < dlm_pkg::MAC_BYTES; i++) begin
			red.sum0 = red.sum0 + 19'(p0[i]);
			red.sum1 = red.sum1 + 19'(p1[i]);
			if ((c0[8*i +: 8] != 8'd0) && (!red.max0_v || (p0[i] > red.max0))) begin
				red.max0   = p0[i];
				red.max0_v = 1'b1;
			end
		end
	end
endmodule

// File: bench/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_ITEMS = 850;
	localparam int HOLD_AT_BEAT = 400;
	localparam int HOLD_CYCLES  = 120;

	logic clk;
	logic arst_n;

	dlm_stream_if #(.payload_t(dlm_pkg::cmd_t)) cmd_ch ();
	dlm_stream_if #(.payload_t(dlm_pkg::rsp_t)) rsp_ch ();

	dual_lane_int8_mac_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the block's state.
	logic [7:0]  shadow_mem [131072];
	bit          mem_known  [131072];
	logic [63:0] shadow_cw0 [512];
	logic [63:0] shadow_cw1 [512];
	bit          cw0_known  [512];
	bit          cw1_known  [512];
	logic [16:0] vec_base, ld_base, st_base;
	logic [8:0]  cf_base;
	logic [31:0] acc0, acc1;

	dlm_pkg::rsp_t expected_rsp [$];
	int   mismatches;
	int   idle_cycles = 0;
	int   rsp_beats;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic void put_byte(logic [16:0] a, logic [7:0] b);
		shadow_mem[a] = b;
		mem_known[a]  = 1'b1;
	endfunction

	function automatic logic [31:0] get_word(logic [16:0] a);
		logic [31:0] v;
		for (int i = 0; i < 4; i++)
			v[8*i +: 8] = shadow_mem[17'(a + 17'(i))];
		return v;
	endfunction

	function automatic void put_word(logic [16:0] a, logic [31:0] v);
		for (int i = 0; i < 4; i++)
			put_byte(17'(a + 17'(i)), v[8*i +: 8]);
	endfunction

	function automatic logic [7:0] clamp_to_byte(logic [31:0] a, logic [4:0] sh, bit relu);
		int v;
		v = $signed(a) >>> sh;
		if (v > dlm_pkg::CLAMP_HI)
			v = dlm_pkg::CLAMP_HI;
		if (relu && v < 0)
			v = 0;
		else if (v < dlm_pkg::CLAMP_LO)
			v = dlm_pkg::CLAMP_LO;
		return v[7:0];
	endfunction

	// Works out the response to one command and updates the shadow state.
	function automatic dlm_pkg::rsp_t compute_rsp(dlm_pkg::cmd_t c);
		logic [16:0] ma;
		logic [8:0]  ca;
		logic [63:0] rd;
		logic [1:0]  st;
		logic [1:0]  sel;
		logic [31:0] v0, v1;
		int          m, c0, c1, p0, p1;
		dlm_pkg::rsp_t r;
		rd  = '0;
		st  = dlm_pkg::ST_OK;
		sel = c.opcode[1:0];
		case (c.action)
			dlm_pkg::ACT_EXEC: begin
				case (c.opcode)
					dlm_pkg::OP_VB_SET: vec_base = c.mem_offset;
					dlm_pkg::OP_VB_ADD: vec_base = vec_base + c.mem_offset;
					dlm_pkg::OP_LB_SET: ld_base = c.mem_offset;
					dlm_pkg::OP_LB_ADD: ld_base = ld_base + c.mem_offset;
					dlm_pkg::OP_SB_SET: st_base = c.mem_offset;
					dlm_pkg::OP_SB_ADD: st_base = st_base + c.mem_offset;
					dlm_pkg::OP_CB_SET: cf_base = c.coeff_offset;
					dlm_pkg::OP_CB_ADD: cf_base = cf_base + c.coeff_offset;
					dlm_pkg::OP_STORE, dlm_pkg::OP_STORE0, dlm_pkg::OP_STORE1,
					dlm_pkg::OP_RELU, dlm_pkg::OP_RELU0, dlm_pkg::OP_RELU1: begin
						if (c.coeff_offset >= dlm_pkg::SHIFT_LIMIT) begin
							st = dlm_pkg::ST_SHIFT;
						end else begin
							ma = st_base + c.mem_offset;
							if (sel != dlm_pkg::SEL_LANE1)
								put_byte(ma, clamp_to_byte(acc0, c.coeff_offset[4:0],
									c.opcode >= dlm_pkg::OP_RELU));
							if (sel != dlm_pkg::SEL_LANE0)
								put_byte(17'(ma + 17'd1), clamp_to_byte(acc1,
									c.coeff_offset[4:0], c.opcode >= dlm_pkg::OP_RELU));
						end
					end
					dlm_pkg::OP_SAVE, dlm_pkg::OP_SAVE0, dlm_pkg::OP_SAVE1: begin
						ma = st_base + c.mem_offset;
						if (ma[0]) begin
							st = dlm_pkg::ST_ODD;
						end else begin
							if (c.opcode != dlm_pkg::OP_SAVE1)
								put_word(ma, acc0);
							if (c.opcode != dlm_pkg::OP_SAVE0)
								put_word(17'(ma + 17'd4), acc1);
						end
					end
					dlm_pkg::OP_LOAD, dlm_pkg::OP_LOAD0, dlm_pkg::OP_LOAD1,
					dlm_pkg::OP_LADD, dlm_pkg::OP_LADD0, dlm_pkg::OP_LADD1: begin
						ma = ld_base + c.mem_offset;
						if (ma[0]) begin
							st = dlm_pkg::ST_ODD;
						end else begin
							v0 = get_word(ma);
							v1 = get_word(17'(ma + 17'd4));
							if (sel != dlm_pkg::SEL_LANE1)
								acc0 = (c.opcode >= dlm_pkg::OP_LADD) ? acc0 + v0 : v0;
							if (sel != dlm_pkg::SEL_LANE0)
								acc1 = (c.opcode >= dlm_pkg::OP_LADD) ? acc1 + v1 : v1;
						end
					end
					dlm_pkg::OP_MACC, dlm_pkg::OP_MMAX, dlm_pkg::OP_MACCZ,
					dlm_pkg::OP_MMAXZ, dlm_pkg::OP_MMAXN: begin
						ma = vec_base + c.mem_offset;
						if (ma[0]) begin
							st = dlm_pkg::ST_ODD;
						end else begin
							ca = cf_base + c.coeff_offset;
							if (c.opcode[1]) begin
								acc0 = '0;
								acc1 = '0;
							end
							if (c.opcode[2]) begin
								acc0 = dlm_pkg::ACC_MIN;
								acc1 = '0;
							end
							for (int i = 0; i < dlm_pkg::MAC_BYTES; i++) begin
								m  = int'($signed(shadow_mem[17'(ma + 17'(i))]));
								c0 = int'($signed(shadow_cw0[ca][8*i +: 8]));
								c1 = int'($signed(shadow_cw1[ca][8*i +: 8]));
								p0 = c0 * m;
								p1 = c1 * m;
								if (c.opcode[0]) begin
									if (c0 != 0 && p0 > int'($signed(acc0)))
										acc0 = p0;
								end else begin
									acc0 = acc0 + p0;
								end
								acc1 = acc1 + p1;
							end
						end
					end
					default: st = dlm_pkg::ST_UNKNOWN;
				endcase
			end
			dlm_pkg::ACT_HOST_WR: begin
				for (int i = 0; i < 8; i++)
					put_byte(17'(c.mem_offset + 17'(i)), c.write_data[8*i +: 8]);
			end
			dlm_pkg::ACT_COEF0_WR: begin
				shadow_cw0[c.coeff_offset] = c.write_data;
				cw0_known[c.coeff_offset]  = 1'b1;
			end
			dlm_pkg::ACT_COEF1_WR: begin
				shadow_cw1[c.coeff_offset] = c.write_data;
				cw1_known[c.coeff_offset]  = 1'b1;
			end
			dlm_pkg::ACT_HOST_RD: begin
				for (int i = 0; i < 8; i++)
					rd[8*i +: 8] = shadow_mem[17'(c.mem_offset + 17'(i))];
			end
			default: st = dlm_pkg::ST_UNKNOWN;
		endcase
		r.acc_lane0 = acc0;
		r.acc_lane1 = acc1;
		r.read_data = rd;
		r.status    = st;
		return r;
	endfunction

	// Sends one command beat after a random gap and records its response.
	// Ready is sampled mid-cycle, where it has settled, and the beat moves at the next edge.
	task automatic send_cmd(dlm_pkg::cmd_t c);
		int gap;
		bit taken;
		gap = $urandom_range(0, 11);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data  <= c;
		expected_rsp.push_back(compute_rsp(c));
		do begin
			@(negedge clk);
			taken = cmd_ch.ready;
			@(posedge clk);
		end while (!taken);
	endtask

	function automatic dlm_pkg::cmd_t make_cmd(logic [2:0] act, logic [5:0] op,
		logic [16:0] moff, logic [8:0] coff, logic [63:0] wd);
		dlm_pkg::cmd_t c;
		c.action       = act;
		c.opcode       = op;
		c.mem_offset   = moff;
		c.coeff_offset = coff;
		c.write_data   = wd;
		return c;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic bit window_known(logic [16:0] a);
		for (int i = 0; i < 8; i++)
			if (!mem_known[17'(a + 17'(i))])
				return 1'b0;
		return 1'b1;
	endfunction

	// Fills any never-written memory or coefficient word that a command would read, then sends it.
	task automatic send_safe(dlm_pkg::cmd_t c);
		logic [16:0] ma;
		logic [8:0]  ca;
		bit          reads;
		reads = 1'b0;
		if (c.action == dlm_pkg::ACT_HOST_RD) begin
			ma    = c.mem_offset;
			reads = 1'b1;
		end else if (c.action == dlm_pkg::ACT_EXEC) begin
			case (c.opcode)
				dlm_pkg::OP_LOAD, dlm_pkg::OP_LOAD0, dlm_pkg::OP_LOAD1,
				dlm_pkg::OP_LADD, dlm_pkg::OP_LADD0, dlm_pkg::OP_LADD1: begin
					ma    = ld_base + c.mem_offset;
					reads = !ma[0];
				end
				dlm_pkg::OP_MACC, dlm_pkg::OP_MMAX, dlm_pkg::OP_MACCZ,
				dlm_pkg::OP_MMAXZ, dlm_pkg::OP_MMAXN: begin
					ma    = vec_base + c.mem_offset;
					reads = !ma[0];
					ca    = cf_base + c.coeff_offset;
					if (reads && !cw0_known[ca])
						send_cmd(make_cmd(dlm_pkg::ACT_COEF0_WR, 6'($urandom()),
							17'($urandom()), ca, rand64()));
					if (reads && !cw1_known[ca])
						send_cmd(make_cmd(dlm_pkg::ACT_COEF1_WR, 6'($urandom()),
							17'($urandom()), ca, rand64()));
				end
				default: reads = 1'b0;
			endcase
		end
		if (reads && !window_known(ma))
			send_cmd(make_cmd(dlm_pkg::ACT_HOST_WR, 6'($urandom()), ma, 9'($urandom()),
				rand64()));
		send_cmd(c);
	endtask

	task automatic report(string field, logic [63:0] got, logic [63:0] want);
		$display("beat %0d: %s got %h expected %h", rsp_beats, field, got, want);
		mismatches++;
	endtask

	// Receiver: random stalls, stretches with no stalls, one long hold-off, and a field-by-field check.
	// The beat is sampled mid-cycle and counts as taken at the following edge.
	initial begin
		int            gap;
		bit            seen;
		dlm_pkg::rsp_t got;
		dlm_pkg::rsp_t want;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, 11);
			if ((rsp_beats / 200) % 2 == 1)
				gap = 0;
			if (rsp_beats == HOLD_AT_BEAT)
				gap = HOLD_CYCLES;
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do begin
				@(negedge clk);
				seen = rsp_ch.valid;
				got  = rsp_ch.data;
				@(posedge clk);
			end while (!seen);
			rsp_beats++;
			if (expected_rsp.size() == 0) begin
				$display("beat %0d: response with nothing expected", rsp_beats);
				mismatches++;
			end else begin
				want = expected_rsp.pop_front();
				if (got.acc_lane0 !== want.acc_lane0)
					report("acc_lane0", 64'(got.acc_lane0), 64'(want.acc_lane0));
				if (got.acc_lane1 !== want.acc_lane1)
					report("acc_lane1", 64'(got.acc_lane1), 64'(want.acc_lane1));
				if (got.read_data !== want.read_data)
					report("read_data", got.read_data, want.read_data);
				if (got.status !== want.status)
					report("status", 64'(got.status), 64'(want.status));
			end
		end
	end

	// Watchdog on cycles in which no beat moves on either channel.
	always @(negedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic test_pointers();
		send_cmd(make_cmd(dlm_pkg::ACT_EXEC, dlm_pkg::OP_VB_SET, 17'h1ffff, 9'h1ff, '0));
		send_cmd(make_cmd(dlm_pkg::ACT_EXEC, dlm_pkg::OP_VB_ADD, 17'h00003, 9'h000, '1));
		send_cmd(make_cmd(dlm_pkg::ACT_EXEC, dlm_pkg::OP_LB_SET, 17'h1fffe, 9'h0aa, '0));
		send_cmd(make_cmd(dlm_pkg::ACT_EXEC, dlm_pkg::OP_LB_ADD, 17'h00004, 9'h155, '0));
		send_cmd(make_cmd(dlm_pkg::ACT_EXEC, dlm_pkg::OP_SB_SET, 17'h1fffc, 9'h000, '0));
		send_cmd(make_cmd(dlm_pkg::ACT_EXEC, dlm_pkg::OP_SB_ADD, 17'h00000, 9'h1ff, '0));
		send_cmd(make_cmd(dlm_pkg::ACT_EXEC, dlm_pkg::OP_CB_SET, 17'h1ffff, 9'h1fe, '0));
		send_cmd(make_cmd(dlm_pkg::ACT_EXEC, dlm_pkg::OP_CB_ADD, 17'h00000, 9'h003, '0));
	endtask

	task automatic test_host_and_macc();
		// A host window that wraps past the top of memory.
		send_cmd(make_cmd(dlm_pkg::ACT_HOST_WR, 6'd0, 17'h1fffc, 9'd0,
			64'h7f80_ff01_807f_0180));
		send_cmd(make_cmd(dlm_pkg::ACT_HOST_RD, 6'd0, 17'h1fffd, 9'd0, '0));
		send_cmd(make_cmd(dlm_pkg::ACT_COEF0_WR, 6'd0, 17'd0, 9'h1ff, '1));
		send_cmd(make_cmd(dlm_pkg::ACT_COEF1_WR, 6'd0, 17'd0, 9'h1ff,
			64'h8080_8080_7f7f_7f7f));
		send_cmd(make_cmd(dlm_pkg::ACT_COEF0_WR, 6'd0, 17'd0, 9'h001,
			64'h0080_0001_00ff_7f00));
		send_cmd(make_cmd(dlm_pkg::ACT_COEF1_WR, 6'd0, 17'd0, 9'h001, '0));
		send_safe(make_cmd(dlm_pkg::ACT_EXEC, dlm_pkg::OP_MACCZ, 17'h00001, 9'h1fe, '0));
		send_safe(make_cmd(dlm_pkg::ACT_EXEC, dlm_pkg::OP_MACC, 17'h00001, 9'h1fe, '0));
		send_safe(make_cmd(dlm_pkg::ACT_EXEC, dlm_pkg::OP_MMAXN, 17'h00001, 9'h000, '0));
		send_safe(make_cmd(dlm_pkg::ACT_EXEC, dlm_pkg::OP_MMAX, 17'h00001, 9'h1fe, '0));
		send_safe(make_cmd(dlm_pkg::ACT_EXEC, dlm_pkg::OP_MMAXZ, 17'h00001, 9'h000, '0));
	endtask

	task automatic test_store_save_load();
		send_cmd(make_cmd(dlm_pkg::ACT_EXEC, dlm_pkg::OP_STORE, 17'h00003, 9'd0, '0));
		send_cmd(make_cmd(dlm_pkg::ACT_EXEC, dlm_pkg::OP_RELU0, 17'h00010, 9'd31, '0));
		send_cmd(make_cmd(dlm_pkg::ACT_EXEC, dlm_pkg::OP_STORE1, 17'h00011, 9'd1, '0));
		send_cmd(make_cmd(dlm_pkg::ACT_EXEC, dlm_pkg::OP_SAVE, 17'h00008, 9'd0, '0));
		send_cmd(make_cmd(dlm_pkg::ACT_EXEC, dlm_pkg::OP_SAVE0, 17'h00020, 9'd0, '0));
		send_cmd(make_cmd(dlm_pkg::ACT_EXEC, dlm_pkg::OP_SAVE1, 17'h00030, 9'd0, '0));
		send_safe(make_cmd(dlm_pkg::ACT_EXEC, dlm_pkg::OP_LADD, 17'h00008, 9'd0, '0));
		send_safe(make_cmd(dlm_pkg::ACT_EXEC, dlm_pkg::OP_LOAD1, 17'h0000a, 9'd0, '0));
	endtask

	task automatic test_errors();
		send_cmd(make_cmd(dlm_pkg::ACT_EXEC, 6'd63, 17'h1ffff, 9'h1ff, '1));
		send_cmd(make_cmd(3'd7, dlm_pkg::OP_MACC, 17'd0, 9'd0, '1));
		send_cmd(make_cmd(dlm_pkg::ACT_EXEC, dlm_pkg::OP_SAVE, 17'h00001, 9'd0, '0));
		send_cmd(make_cmd(dlm_pkg::ACT_EXEC, dlm_pkg::OP_RELU, 17'h00000, 9'd32, '0));
	endtask

	task automatic test_random();
		dlm_pkg::cmd_t c;
		int            pick;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			c    = make_cmd(dlm_pkg::ACT_EXEC, 6'($urandom()), 17'($urandom()),
				9'($urandom()), rand64());
			// Offsets are mostly even so that most memory work gets past the address check.
			if ($urandom_range(0, 9) != 0)
				c.mem_offset[0] = 1'b0;
			if (pick < 8) begin
				c.action = dlm_pkg::ACT_HOST_WR;
			end else if (pick < 14) begin
				c.action = ($urandom_range(0, 1) != 0) ? dlm_pkg::ACT_COEF0_WR
					: dlm_pkg::ACT_COEF1_WR;
			end else if (pick < 20) begin
				c.action = dlm_pkg::ACT_HOST_RD;
			end else if (pick < 30) begin
				c.opcode = 6'($urandom_range(dlm_pkg::OP_VB_SET, dlm_pkg::OP_CB_ADD));
			end else if (pick < 42) begin
				c.opcode       = 6'($urandom_range(dlm_pkg::OP_STORE, dlm_pkg::OP_RELU1));
				c.coeff_offset = ($urandom_range(0, 7) == 0) ? 9'($urandom())
					: 9'($urandom_range(0, 31));
			end else if (pick < 50) begin
				c.opcode = 6'($urandom_range(dlm_pkg::OP_SAVE, dlm_pkg::OP_SAVE1));
			end else if (pick < 62) begin
				c.opcode = 6'($urandom_range(dlm_pkg::OP_LOAD, dlm_pkg::OP_LADD1));
			end else if (pick < 94) begin
				c.opcode = 6'($urandom_range(dlm_pkg::OP_MACC, dlm_pkg::OP_MMAXN));
			end else if (pick < 97) begin
				c.action = 3'($urandom_range(5, 7));
			end
			send_safe(c);
		end
	endtask

	initial begin
		mismatches   = 0;
		rsp_beats    = 0;
		vec_base     = '0;
		ld_base      = '0;
		st_base      = '0;
		cf_base      = '0;
		acc0         = '0;
		acc1         = '0;
		arst_n       = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data  = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_pointers();
		test_host_and_macc();
		test_store_save_load();
		test_errors();
		test_random();
		cmd_ch.valid <= 1'b0;
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
